// ===== rtl/svpf_pkg.sv =====
package svpf_pkg;

    localparam int LEN_BITS     = 24;
    localparam int SAMPLE_BITS  = 16;
    localparam int GAIN_BITS    = 16;
    localparam int GAIN_FRAC    = 12;
    localparam int FRAC_BITS    = 16;
    localparam int DELAY_BITS   = 12;
    localparam int BS_BITS      = 13;
    localparam int FUNC_BITS    = 2;
    localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);

    localparam int PROD1_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int PROD2_BITS = PROD1_BITS + FRAC_BITS + 1;
    localparam int FADE_SHIFT = GAIN_FRAC + FRAC_BITS;
    localparam int ACC_BITS   = PROD2_BITS - FADE_SHIFT + 1;

    localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_TRIGGER = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_FADE    = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_STOP    = 2'd3;

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN       = GAIN_BITS'(1 << GAIN_FRAC);
    localparam logic [BS_BITS-1:0]   BLOCK_SIZE_RESET = BS_BITS'(512);

    typedef struct packed {
        logic mul1_en;
        logic mul2_en;
        logic fading;
    } lane_ctrl_t;

endpackage

// ===== rtl/sample_voice_player_with_fade.sv =====
// A tick that plays a frame with a fade factor to divide passes through the 16-step fade-factor
// divider (ST_DIV) and then ST_MUL1, ST_MUL2 and ST_DONE; other ticks that play skip ST_DIV.
// Items that play nothing (delay, idle, trigger, fade, stop) go straight to ST_DONE.
// One item is in work at a time: the next is accepted only after ST_DONE, which waits on m_ready.
// Reset (aresetn low, synchronous) clears the voice, sets unity gain and a block size of 512.
module sample_voice_player_with_fade (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_wr_en,
    input  logic        [svpf_pkg::BS_BITS-1:0]         cfg_wr_data,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic        [svpf_pkg::FUNC_BITS-1:0]       s_func,
    input  logic        [svpf_pkg::GAIN_BITS-1:0]       s_gain,
    input  logic        [svpf_pkg::LEN_BITS-1:0]        s_sample_length,
    input  logic        [svpf_pkg::DELAY_BITS-1:0]      s_start_delay,
    input  logic                                        s_is_stereo,
    input  logic        [svpf_pkg::LEN_BITS-1:0]        s_fade_len,
    input  logic signed [svpf_pkg::SAMPLE_BITS-1:0]     s_src_left,
    input  logic signed [svpf_pkg::SAMPLE_BITS-1:0]     s_src_right,
    input  logic signed [svpf_pkg::SAMPLE_BITS-1:0]     s_mix_left,
    input  logic signed [svpf_pkg::SAMPLE_BITS-1:0]     s_mix_right,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [svpf_pkg::SAMPLE_BITS-1:0]     m_out_left,
    output logic signed [svpf_pkg::SAMPLE_BITS-1:0]     m_out_right,
    output logic                                        m_consumed,
    output logic                                        m_voice_active,
    output logic                                        m_voice_fading
);

    localparam int LB = svpf_pkg::LEN_BITS;
    localparam int SB = svpf_pkg::SAMPLE_BITS;
    localparam int DB = svpf_pkg::DELAY_BITS;
    localparam int FB = svpf_pkg::FRAC_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [svpf_pkg::BS_BITS-1:0]   bs_reg;
    logic                           active_reg, active_next;
    logic                           fading_reg, fading_next;
    logic                           stereo_reg, stereo_next;
    logic [svpf_pkg::GAIN_BITS-1:0] gain_reg, gain_next;
    logic [LB-1:0]                  pos_reg, pos_next;
    logic [LB-1:0]                  len_reg, len_next;
    logic [DB-1:0]                  delay_reg, delay_next;
    logic [LB-1:0]                  rem_reg, rem_next;
    logic [LB-1:0]                  total_reg, total_next;

    logic                           use_reg, use_next;
    logic                           need_div;
    logic                           clear_voice;
    logic                           stop_voice;
    logic [LB-1:0]                  pos_inc;
    logic [LB-1:0]                  rem_dec;
    logic [svpf_pkg::BS_BITS-1:0]   delay_lim;

    logic                           op_fading_reg;
    logic [svpf_pkg::GAIN_BITS-1:0] op_gain_reg;
    logic [FB-1:0]                  factor_reg;
    logic signed [SB-1:0]           src_l_reg, src_r_reg;
    logic signed [SB-1:0]           mix_l_reg, mix_r_reg;

    logic                           m_valid_reg;
    logic signed [SB-1:0]           out_l_reg, out_r_reg;
    logic                           consumed_reg, vact_reg, vfade_reg;

    logic                           accept;
    logic                           div_start;
    logic                           div_done;
    logic [FB-1:0]                  div_quo;
    logic                           out_load;
    svpf_pkg::lane_ctrl_t           lane_ctrl;
    logic signed [SB-1:0]           lane_l, lane_r;

    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign out_load = state_reg == ST_DONE && (!m_valid_reg || m_ready);
    assign delay_lim = (bs_reg == '0) ? '0 : bs_reg - 1'b1;

    always_comb begin
        active_next = active_reg;
        fading_next = fading_reg;
        stereo_next = stereo_reg;
        gain_next   = gain_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        delay_next  = delay_reg;
        rem_next    = rem_reg;
        total_next  = total_reg;
        use_next    = 1'b0;
        need_div    = 1'b0;
        clear_voice = 1'b0;
        stop_voice  = 1'b0;
        pos_inc     = pos_reg + 1'b1;
        rem_dec     = rem_reg - 1'b1;
        if (accept) begin
            case (s_func)
                svpf_pkg::FUNC_TICK: begin
                    if (active_reg) begin
                        if (delay_reg != '0) begin
                            delay_next = delay_reg - 1'b1;
                        end else if ((fading_reg && rem_reg == '0) || pos_reg >= len_reg) begin
                            clear_voice = 1'b1;
                        end else begin
                            use_next = 1'b1;
                            need_div = fading_reg && rem_reg < total_reg;
                            pos_next = pos_inc;
                            if (fading_reg) begin
                                rem_next = rem_dec;
                                if (rem_dec == '0) begin
                                    stop_voice = 1'b1;
                                end
                            end
                            if (pos_inc == '0 || pos_inc >= len_reg) begin
                                stop_voice = 1'b1;
                            end
                            clear_voice = stop_voice;
                        end
                    end
                end
                svpf_pkg::FUNC_TRIGGER: begin
                    if (s_sample_length != '0) begin
                        fading_next = 1'b0;
                        rem_next    = '0;
                        pos_next    = '0;
                        len_next    = s_sample_length;
                        gain_next   = s_gain;
                        stereo_next = s_is_stereo;
                        active_next = 1'b1;
                        if ({1'b0, s_start_delay} > delay_lim) begin
                            delay_next = delay_lim[DB-1:0];
                        end else begin
                            delay_next = s_start_delay;
                        end
                    end
                end
                svpf_pkg::FUNC_FADE: begin
                    if (active_reg && !fading_reg) begin
                        total_next  = s_fade_len;
                        rem_next    = s_fade_len;
                        fading_next = 1'b1;
                    end
                end
                svpf_pkg::FUNC_STOP: begin
                    clear_voice = 1'b1;
                end
                default: begin
                    clear_voice = 1'b0;
                end
            endcase
            if (clear_voice) begin
                active_next = 1'b0;
                fading_next = 1'b0;
                stereo_next = 1'b0;
                gain_next   = svpf_pkg::UNITY_GAIN;
                pos_next    = '0;
                len_next    = '0;
                delay_next  = '0;
                rem_next    = '0;
            end
        end
    end

    assign div_start = accept && need_div;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (need_div) begin
                        state_next = ST_DIV;
                    end else if (use_next) begin
                        state_next = ST_MUL1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bs_reg      <= svpf_pkg::BLOCK_SIZE_RESET;
            active_reg  <= 1'b0;
            fading_reg  <= 1'b0;
            stereo_reg  <= 1'b0;
            gain_reg    <= svpf_pkg::UNITY_GAIN;
            pos_reg     <= '0;
            len_reg     <= '0;
            delay_reg   <= '0;
            rem_reg     <= '0;
            total_reg   <= '0;
            use_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            fading_reg <= fading_next;
            stereo_reg <= stereo_next;
            gain_reg   <= gain_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            delay_reg  <= delay_next;
            rem_reg    <= rem_next;
            total_reg  <= total_next;
            if (cfg_wr_en) begin
                bs_reg <= cfg_wr_data;
            end
            if (accept) begin
                use_reg <= use_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_fading_reg <= fading_reg;
            op_gain_reg   <= gain_reg;
            factor_reg    <= '1;
            src_l_reg     <= s_src_left;
            src_r_reg     <= stereo_reg ? s_src_right : s_src_left;
            if (s_func == svpf_pkg::FUNC_TICK) begin
                mix_l_reg <= s_mix_left;
                mix_r_reg <= s_mix_right;
            end else begin
                mix_l_reg <= '0;
                mix_r_reg <= '0;
            end
        end else if (div_done) begin
            factor_reg <= div_quo;
        end
        if (out_load) begin
            out_l_reg    <= use_reg ? lane_l : mix_l_reg;
            out_r_reg    <= use_reg ? lane_r : mix_r_reg;
            consumed_reg <= use_reg;
            vact_reg     <= active_reg;
            vfade_reg    <= fading_reg;
        end
    end

    svpf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        lane_ctrl.mul1_en = state_reg == ST_MUL1;
        lane_ctrl.mul2_en = state_reg == ST_MUL2;
        lane_ctrl.fading  = op_fading_reg;
    end

    svpf_lane u_lane_left (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .src    (src_l_reg),
        .gain   (op_gain_reg),
        .factor (factor_reg),
        .mix    (mix_l_reg),
        .result (lane_l)
    );

    svpf_lane u_lane_right (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .src    (src_r_reg),
        .gain   (op_gain_reg),
        .factor (factor_reg),
        .mix    (mix_r_reg),
        .result (lane_r)
    );

    assign m_valid        = m_valid_reg;
    assign m_out_left     = out_l_reg;
    assign m_out_right    = out_r_reg;
    assign m_consumed     = consumed_reg;
    assign m_voice_active = vact_reg;
    assign m_voice_fading = vfade_reg;

    a_fading_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        fading_reg |-> active_reg)
        else $error("Voice is fading while inactive.");

    a_one_item_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("A second transaction was accepted while one is in work.");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("Divider finished outside the divide state.");

    a_div_only_when_fading: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> op_fading_reg && use_reg)
        else $error("Divide state entered for a frame without a fade.");

endmodule

// ===== rtl/svpf_div.sv =====
module svpf_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [svpf_pkg::LEN_BITS-1:0]       dividend,
    input  logic [svpf_pkg::LEN_BITS-1:0]       divisor,
    output logic                                done,
    output logic [svpf_pkg::FRAC_BITS-1:0]      quotient
);

    localparam int LB = svpf_pkg::LEN_BITS;
    localparam int FB = svpf_pkg::FRAC_BITS;

    logic [svpf_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                              done_reg, done_next;
    logic [LB-1:0]                     rem_reg, rem_next;
    logic [LB-1:0]                     dsr_reg, dsr_next;
    logic [FB-1:0]                     quo_reg, quo_next;
    logic [LB:0]                       shifted;
    logic [LB:0]                       diff;
    logic                              ge;

    assign shifted = {rem_reg, 1'b0};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            cnt_next = svpf_pkg::DIV_CNT_BITS'(FB);
            rem_next = dividend;
            dsr_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? diff[LB-1:0] : shifted[LB-1:0];
            quo_next = {quo_reg[FB-2:0], ge};
            if (cnt_reg == svpf_pkg::DIV_CNT_BITS'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/svpf_lane.sv =====
module svpf_lane (
    input  logic                                        aclk,
    input  svpf_pkg::lane_ctrl_t                        ctrl,
    input  logic signed [svpf_pkg::SAMPLE_BITS-1:0]     src,
    input  logic        [svpf_pkg::GAIN_BITS-1:0]       gain,
    input  logic        [svpf_pkg::FRAC_BITS-1:0]       factor,
    input  logic signed [svpf_pkg::SAMPLE_BITS-1:0]     mix,
    output logic signed [svpf_pkg::SAMPLE_BITS-1:0]     result
);

    localparam int P1 = svpf_pkg::PROD1_BITS;
    localparam int P2 = svpf_pkg::PROD2_BITS;
    localparam int AB = svpf_pkg::ACC_BITS;
    localparam int SB = svpf_pkg::SAMPLE_BITS;
    localparam int C1 = P1 - svpf_pkg::GAIN_FRAC;
    localparam int C2 = P2 - svpf_pkg::FADE_SHIFT;
    localparam logic signed [AB-1:0] SMP_MAX = AB'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [AB-1:0] SMP_MIN = -SMP_MAX - AB'(1);

    logic signed [P1-1:0] prod_reg;
    logic signed [P2-1:0] scaled_reg;
    logic signed [AB-1:0] contrib;
    logic signed [AB-1:0] mix_ext;
    logic signed [AB-1:0] sum;

    always_ff @(posedge aclk) begin
        if (ctrl.mul1_en) begin
            prod_reg <= P1'(src * $signed({1'b0, gain}));
        end
        if (ctrl.mul2_en) begin
            scaled_reg <= P2'(prod_reg * $signed({1'b0, factor}));
        end
    end

    always_comb begin
        if (ctrl.fading) begin
            contrib = {{(AB - C2){scaled_reg[P2-1]}}, scaled_reg[P2-1:svpf_pkg::FADE_SHIFT]};
        end else begin
            contrib = {{(AB - C1){prod_reg[P1-1]}}, prod_reg[P1-1:svpf_pkg::GAIN_FRAC]};
        end
        mix_ext = {{(AB - SB){mix[SB-1]}}, mix};
        sum     = mix_ext + contrib;
        if (sum > SMP_MAX) begin
            result = SMP_MAX[SB-1:0];
        end else if (sum < SMP_MIN) begin
            result = SMP_MIN[SB-1:0];
        end else begin
            result = sum[SB-1:0];
        end
    end

endmodule

// ===== tb/sample_voice_player_with_fade_tb.sv =====
`timescale 1ns / 100ps

module sample_voice_player_with_fade_tb;
    import svpf_pkg::*;

    typedef struct {
        logic [FUNC_BITS-1:0]          func;
        logic [GAIN_BITS-1:0]          gain;
        logic [LEN_BITS-1:0]           sample_length;
        logic [DELAY_BITS-1:0]         start_delay;
        logic                          is_stereo;
        logic [LEN_BITS-1:0]           fade_len;
        logic signed [SAMPLE_BITS-1:0] src_left;
        logic signed [SAMPLE_BITS-1:0] src_right;
        logic signed [SAMPLE_BITS-1:0] mix_left;
        logic signed [SAMPLE_BITS-1:0] mix_right;
    } voice_cmd_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic                          consumed;
        logic                          active;
        logic                          fading;
    } voice_frame_t;

    class voice_scoreboard;
        bit [BS_BITS-1:0]    block_size;
        bit                  active;
        bit                  fading;
        bit                  stereo;
        bit [GAIN_BITS-1:0]  gain;
        bit [LEN_BITS-1:0]   position;
        bit [LEN_BITS-1:0]   play_len;
        bit [DELAY_BITS-1:0] delay_left;
        bit [LEN_BITS-1:0]   fade_left;
        bit [LEN_BITS-1:0]   fade_total;
        voice_frame_t        pending_frames[$];
        int                  errors;
        int                  frames_mixed;
        int                  fades_begun;

        function new();
            block_size = BLOCK_SIZE_RESET;
            clear_voice();
            fade_total = 0;
            errors = 0;
            frames_mixed = 0;
            fades_begun = 0;
        endfunction

        function void clear_voice();
            active = 0;
            fading = 0;
            stereo = 0;
            gain = UNITY_GAIN;
            position = 0;
            play_len = 0;
            delay_left = 0;
            fade_left = 0;
        endfunction

        function longint scaled(longint s, longint factor);
            longint p;
            p = s * longint'(gain);
            if (!fading) begin
                return p >>> GAIN_FRAC;
            end
            return (p * factor) >>> FADE_SHIFT;
        endfunction

        function logic signed [SAMPLE_BITS-1:0] clamp(longint v);
            if (v > 32767) begin
                return 16'sh7fff;
            end
            if (v < -32768) begin
                return 16'sh8000;
            end
            return v[SAMPLE_BITS-1:0];
        endfunction

        // Predicts the result of one accepted transaction and returns whether it had any effect.
        function bit note_input(voice_cmd_t c);
            voice_frame_t      f;
            bit                did;
            int                lim;
            longint            ml;
            longint            mr;
            longint            sl;
            longint            sr;
            longint unsigned   factor;
            f.out_left = 0;
            f.out_right = 0;
            f.consumed = 0;
            did = 0;
            case (c.func)
                FUNC_TRIGGER: begin
                    if (c.sample_length != 0) begin
                        lim = (block_size == 0) ? 0 : int'(block_size) - 1;
                        fading = 0;
                        fade_left = 0;
                        position = 0;
                        play_len = c.sample_length;
                        gain = c.gain;
                        stereo = c.is_stereo;
                        delay_left = (c.start_delay > lim) ? DELAY_BITS'(lim) : c.start_delay;
                        active = 1;
                        did = 1;
                    end
                end
                FUNC_FADE: begin
                    if (active && !fading) begin
                        fade_total = c.fade_len;
                        fade_left = c.fade_len;
                        fading = 1;
                        fades_begun++;
                        did = 1;
                    end
                end
                FUNC_STOP: begin
                    did = active;
                    clear_voice();
                end
                default: begin
                    f.out_left = c.mix_left;
                    f.out_right = c.mix_right;
                    if (active) begin
                        did = 1;
                        if (delay_left != 0) begin
                            delay_left--;
                        end else if ((fading && fade_left == 0) || position >= play_len) begin
                            clear_voice();
                        end else begin
                            ml = c.mix_left;
                            mr = c.mix_right;
                            sl = c.src_left;
                            sr = stereo ? longint'(c.src_right) : longint'(c.src_left);
                            factor = 65535;
                            if (fading && fade_left < fade_total) begin
                                factor = (longint'(fade_left) << FRAC_BITS) / fade_total;
                            end
                            if (factor > 65535) begin
                                factor = 65535;
                            end
                            f.out_left = clamp(ml + scaled(sl, longint'(factor)));
                            f.out_right = clamp(mr + scaled(sr, longint'(factor)));
                            f.consumed = 1;
                            frames_mixed++;
                            position = position + 1'b1;
                            if (fading) begin
                                fade_left--;
                                if (fade_left == 0) begin
                                    clear_voice();
                                end
                            end
                            if (active && (position == 0 || position >= play_len)) begin
                                clear_voice();
                            end
                        end
                    end
                end
            endcase
            f.active = active;
            f.fading = fading;
            pending_frames.push_back(f);
            return did;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        task check_result(voice_frame_t got);
            voice_frame_t want;
            if (pending_frames.size() == 0) begin
                report("result transaction with no expected result waiting");
                return;
            end
            want = pending_frames.pop_front();
            if (got.out_left !== want.out_left) begin
                report($sformatf("out_left %0d, expected %0d", got.out_left, want.out_left));
            end
            if (got.out_right !== want.out_right) begin
                report($sformatf("out_right %0d, expected %0d", got.out_right, want.out_right));
            end
            if (got.consumed !== want.consumed) begin
                report($sformatf("consumed %b, expected %b", got.consumed, want.consumed));
            end
            if (got.active !== want.active) begin
                report($sformatf("voice_active %b, expected %b", got.active, want.active));
            end
            if (got.fading !== want.fading) begin
                report($sformatf("voice_fading %b, expected %b", got.fading, want.fading));
            end
        endtask
    endclass

    localparam int LONG_HOLD = 300;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [BS_BITS-1:0]            cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [FUNC_BITS-1:0]          s_func;
    logic [GAIN_BITS-1:0]          s_gain;
    logic [LEN_BITS-1:0]           s_sample_length;
    logic [DELAY_BITS-1:0]         s_start_delay;
    logic                          s_is_stereo;
    logic [LEN_BITS-1:0]           s_fade_len;
    logic signed [SAMPLE_BITS-1:0] s_src_left;
    logic signed [SAMPLE_BITS-1:0] s_src_right;
    logic signed [SAMPLE_BITS-1:0] s_mix_left;
    logic signed [SAMPLE_BITS-1:0] s_mix_right;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_out_left;
    logic signed [SAMPLE_BITS-1:0] m_out_right;
    logic                          m_consumed;
    logic                          m_voice_active;
    logic                          m_voice_fading;

    voice_scoreboard sb = new();
    bit tx_idling;
    bit rx_idling;
    bit hold_req;
    int sent;
    int effective;
    int settings_done;

    sample_voice_player_with_fade u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_gain          (s_gain),
        .s_sample_length (s_sample_length),
        .s_start_delay   (s_start_delay),
        .s_is_stereo     (s_is_stereo),
        .s_fade_len      (s_fade_len),
        .s_src_left      (s_src_left),
        .s_src_right     (s_src_right),
        .s_mix_left      (s_mix_left),
        .s_mix_right     (s_mix_right),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_consumed      (m_consumed),
        .m_voice_active  (m_voice_active),
        .m_voice_fading  (m_voice_fading)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_BITS-1:0] rand_len();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return LEN_BITS'($urandom);
            2: return LEN_BITS'(1);
            default: return LEN_BITS'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [LEN_BITS-1:0] rand_fade_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEN_BITS'($urandom);
            2: return LEN_BITS'(1);
            default: return LEN_BITS'($urandom_range(2, 12));
        endcase
    endfunction

    // Long delays only where the block size clamps them.
    function automatic logic [DELAY_BITS-1:0] rand_delay();
        if (sb.block_size <= 64) begin
            return DELAY_BITS'($urandom);
        end
        if ($urandom_range(0, 7) == 0) begin
            return DELAY_BITS'($urandom_range(0, 40));
        end
        return DELAY_BITS'($urandom_range(0, 3));
    endfunction

    function automatic voice_cmd_t make_cmd(logic [FUNC_BITS-1:0] fn);
        voice_cmd_t c;
        c.func = fn;
        c.gain = GAIN_BITS'($urandom);
        c.sample_length = LEN_BITS'($urandom);
        c.start_delay = DELAY_BITS'($urandom);
        c.is_stereo = 1'($urandom);
        c.fade_len = LEN_BITS'($urandom);
        c.src_left = rand_sample();
        c.src_right = rand_sample();
        c.mix_left = rand_sample();
        c.mix_right = rand_sample();
        return c;
    endfunction

    task automatic send_item(voice_cmd_t c);
        s_valid <= 1'b1;
        s_func <= c.func;
        s_gain <= c.gain;
        s_sample_length <= c.sample_length;
        s_start_delay <= c.start_delay;
        s_is_stereo <= c.is_stereo;
        s_fade_len <= c.fade_len;
        s_src_left <= c.src_left;
        s_src_right <= c.src_right;
        s_mix_left <= c.mix_left;
        s_mix_right <= c.mix_right;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sent++;
        if (sb.note_input(c)) begin
            effective++;
        end
        if (tx_idling && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic play_trigger(logic [GAIN_BITS-1:0] g, logic [LEN_BITS-1:0] len,
                                logic [DELAY_BITS-1:0] d, logic st);
        voice_cmd_t c;
        c = make_cmd(FUNC_TRIGGER);
        c.gain = g;
        c.sample_length = len;
        c.start_delay = d;
        c.is_stereo = st;
        send_item(c);
    endtask

    task automatic play_ticks(int n);
        repeat (n) send_item(make_cmd(FUNC_TICK));
    endtask

    task automatic play_fade(logic [LEN_BITS-1:0] len);
        voice_cmd_t c;
        c = make_cmd(FUNC_FADE);
        c.fade_len = len;
        send_item(c);
    endtask

    task automatic play_mix(logic signed [SAMPLE_BITS-1:0] src, logic signed [SAMPLE_BITS-1:0] mix);
        voice_cmd_t c;
        c = make_cmd(FUNC_TICK);
        c.src_left = src;
        c.src_right = src;
        c.mix_left = mix;
        c.mix_right = mix;
        send_item(c);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_frames.size() != 0) @(posedge aclk);
    endtask

    task automatic set_block_size(logic [BS_BITS-1:0] v);
        wait_drained();
        repeat (25) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.block_size = v;
        settings_done++;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_items();
        voice_cmd_t c;
        play_mix(16'sh1234, 16'sh7fff);
        play_fade(5);
        send_item(make_cmd(FUNC_STOP));
        play_trigger(16'hffff, 0, 0, 1'b0);
        play_trigger(16'hffff, 3, 12'hfff, 1'b0);
        play_ticks(2);
        play_mix(16'sh7fff, 16'sh7fff);
        play_mix(16'sh8000, 16'sh8000);
        play_mix(16'sh4000, 16'sh0000);
        play_ticks(1);
        play_trigger(16'h0000, 24'hffffff, 0, 1'b1);
        play_ticks(1);
        play_trigger(UNITY_GAIN, 24'hffffff, 0, 1'b1);
        play_ticks(1);
        play_fade(3);
        play_fade(5);
        play_ticks(3);
        play_trigger(16'h2000, 10, 0, 1'b0);
        play_fade(0);
        play_ticks(1);
        play_trigger(UNITY_GAIN, 5, 1, 1'b1);
        c = make_cmd(FUNC_STOP);
        send_item(c);
        play_ticks(1);
    endtask

    // Mostly complete note sequences with random content, the rest random noise.
    task automatic random_phase(int target, bit long_hold, bit sender_pause);
        int                    base;
        int                    lim;
        int                    total;
        int                    k;
        bit                    held;
        bit                    paused;
        logic [LEN_BITS-1:0]   len;
        logic [DELAY_BITS-1:0] d;
        voice_cmd_t            c;
        base = sent;
        held = 0;
        paused = 0;
        while (sent - base < target) begin
            if ($urandom_range(0, 9) < 8) begin
                len = rand_len();
                d = rand_delay();
                lim = (sb.block_size == 0) ? 0 : int'(sb.block_size) - 1;
                if (d < lim) begin
                    lim = d;
                end
                total = (len <= 24) ? lim + int'(len) + $urandom_range(0, 2)
                                    : lim + $urandom_range(1, 30);
                play_trigger(GAIN_BITS'($urandom), len, d, 1'($urandom));
                if ($urandom_range(0, 1) == 0) begin
                    k = $urandom_range(0, total);
                    play_ticks(k);
                    play_fade(rand_fade_len());
                    play_ticks(total - k);
                end else begin
                    play_ticks(total);
                end
                if ($urandom_range(0, 5) == 0) begin
                    send_item(make_cmd(FUNC_STOP));
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    c = make_cmd(FUNC_BITS'($urandom_range(0, 3)));
                    c.start_delay = rand_delay();
                    send_item(c);
                end
            end
            if (long_hold && !held && sent - base > target / 3) begin
                hold_req = 1;
                held = 1;
            end
            if (sender_pause && !paused && sent - base > target / 2) begin
                wait_drained();
                paused = 1;
            end
        end
    endtask

    initial begin
        int hold_left;
        voice_frame_t got;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                got.out_left = m_out_left;
                got.out_right = m_out_right;
                got.consumed = m_consumed;
                got.active = m_voice_active;
                got.fading = m_voice_fading;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req = 0;
            end else if (hold_left == 0 && rx_idling && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 8);
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [BS_BITS-1:0] sizes[7];
        int                 targets[7];
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_func <= FUNC_TICK;
        s_gain <= '0;
        s_sample_length <= '0;
        s_start_delay <= '0;
        s_is_stereo <= 1'b0;
        s_fade_len <= '0;
        s_src_left <= '0;
        s_src_right <= '0;
        s_mix_left <= '0;
        s_mix_right <= '0;
        sizes = '{13'd0, 13'd1, 13'd6, 13'd4096, 13'd8191, 13'd40, 13'd512};
        targets = '{250, 250, 300, 250, 250, 300, 250};
        tx_idling = 1;
        rx_idling = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_block_size(3);
        directed_items();
        for (int i = 0; i < 7; i++) begin
            set_block_size(sizes[i]);
            tx_idling = (i != 6) && (i % 3 != 2);
            rx_idling = (i != 6) && (i % 3 != 1);
            random_phase(targets[i], i == 2, i == 4);
        end
        wait_drained();
        repeat (30) @(posedge aclk);
        $display("Covered %0d transactions (%0d with effect), %0d frames mixed, %0d fades begun,",
                 sent, effective, sb.frames_mixed, sb.fades_begun);
        $display("over %0d block-size settings from 0 to 8191, with backpressure and drain pauses.",
                 settings_done);
        if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
